>>> hdl/hdlc_async_deframer_fcs_check_defines.svh
// Assertion macros used by the checker file.
`ifndef HDLC_ASYNC_DEFRAMER_FCS_CHECK_DEFINES_SVH
`define HDLC_ASYNC_DEFRAMER_FCS_CHECK_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define HDLC_DFR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define HDLC_DFR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/hdlc_dfr_pkg.sv
package hdlc_dfr_pkg;

   localparam int CFG_W               = 13;
   localparam int FRAME_LEN_W         = 12;
   localparam int MAX_FRAME_BYTES_DEF = 4096;
   localparam int MIN_FRAME_BYTES     = 3;

   localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

   localparam logic [7:0]  FLAG_OCTET = 8'h7E;
   localparam logic [7:0]  ESC_OCTET  = 8'h7D;
   localparam logic [7:0]  ESC_XOR    = 8'h20;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_XOROUT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'h8408;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_RECV = 2'd1,
      PH_ESC  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_PENDING  = 3'd1,
      ST_GOOD     = 3'd2,
      ST_BADFCS   = 3'd3,
      ST_ABORT    = 3'd4,
      ST_OVERFLOW = 3'd5,
      ST_SHORT    = 3'd6
   } status_type;

   typedef struct packed {
      status_type             status;
      logic                   payload_valid;
      logic [7:0]             payload_byte;
      logic [FRAME_LEN_W-1:0] frame_length;
   } result_type;

   // Reflected CRC-16 update over one byte, least significant bit first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> hdl/hdlc_async_deframer_fcs_check.sv
// An accepted word waits in the input register until the result register is free, then its
// result is registered there. Throughput: one word per cycle while rsp_stall is low.
// The CRC byte update and phase step are combinational.
// Reset (synchronous, active high) returns the deframer to idle, clears the stored count,
// sets the running CRC to all ones, empties both word registers and sets the limit to 4096.
module hdlc_async_deframer_fcs_check import hdlc_dfr_pkg::*; #(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CFG_W-1:0]       csr_write_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [2:0]             rsp_status,
   output logic                   rsp_payload_valid,
   output logic [7:0]             rsp_payload_byte,
   output logic [FRAME_LEN_W-1:0] rsp_frame_length
);

   logic [CFG_W-1:0] max_len_ff;
   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             out_valid_ff, out_valid_in;
   result_type       out_result_ff;
   result_type       core_result;
   logic             advance;
   logic             step;
   logic             accept;

   // The result register frees up when it is empty or being taken this cycle.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (step) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= CFG_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            max_len_ff <= csr_write_data;
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_rx_byte;
      end
      if (step) begin
         out_result_ff <= core_result;
      end
   end

   hdlc_dfr_core #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .rx_byte       (in_byte_ff),
      .max_frame_len (max_len_ff),
      .result        (core_result)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_result_ff.status;
   assign rsp_payload_valid = out_result_ff.payload_valid;
   assign rsp_payload_byte  = out_result_ff.payload_byte;
   assign rsp_frame_length  = out_result_ff.frame_length;

endmodule

>>> hdl/hdlc_dfr_core.sv
module hdlc_dfr_core import hdlc_dfr_pkg::*; #(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       rx_byte,
   input  logic [CFG_W-1:0] max_frame_len,
   output result_type       result
);

   localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   localparam logic [CMP_W-1:0] LIM_LO = CMP_W'(MIN_FRAME_BYTES);
   localparam logic [CMP_W-1:0] LIM_HI = CMP_W'(MAX_FRAME_BYTES);

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       held_ff [2];
   logic [7:0]       held_in [2];

   logic [CMP_W-1:0] cfg_ext;
   logic [CMP_W-1:0] limit;
   logic [CMP_W-1:0] count_ext;
   logic             take;
   logic [7:0]       data;

   assign cfg_ext   = CMP_W'(max_frame_len);
   assign count_ext = CMP_W'(count_ff);

   always_comb begin
      if (cfg_ext < LIM_LO) begin
         limit = LIM_LO;
      end else if (cfg_ext > LIM_HI) begin
         limit = LIM_HI;
      end else begin
         limit = cfg_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         crc_ff   <= CRC_INIT;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         crc_ff   <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff[0] <= held_in[0];
      held_ff[1] <= held_in[1];
   end

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      crc_in     = crc_ff;
      held_in[0] = held_ff[0];
      held_in[1] = held_ff[1];
      result     = '0;
      result.status = ST_IDLE;
      take       = 1'b0;
      data       = rx_byte;
      if (step) begin
         unique case (phase_ff)
            PH_RECV: begin
               if (rx_byte == FLAG_OCTET) begin
                  phase_in = PH_IDLE;
                  if (count_ff < CNT_W'(2)) begin
                     result.status = ST_SHORT;
                  end else if ({held_ff[1], held_ff[0]} == (crc_ff ^ CRC_XOROUT)) begin
                     result.status       = ST_GOOD;
                     result.frame_length = FRAME_LEN_W'(count_ext - CMP_W'(2));
                  end else begin
                     result.status = ST_BADFCS;
                  end
               end else if (rx_byte == ESC_OCTET) begin
                  phase_in      = PH_ESC;
                  result.status = ST_PENDING;
               end else begin
                  take = 1'b1;
               end
            end
            PH_ESC: begin
               if (rx_byte == FLAG_OCTET) begin
                  phase_in      = PH_IDLE;
                  result.status = ST_ABORT;
               end else begin
                  take = 1'b1;
                  data = rx_byte ^ ESC_XOR;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               if (rx_byte == FLAG_OCTET) begin
                  phase_in      = PH_RECV;
                  count_in      = '0;
                  crc_in        = CRC_INIT;
                  result.status = ST_PENDING;
               end
            end
         endcase

         if (take) begin
            if (count_ext >= limit) begin
               phase_in      = PH_IDLE;
               result.status = ST_OVERFLOW;
            end else begin
               // The two newest data bytes are held back; at the closing flag they are the FCS.
               if (count_ff < CNT_W'(2)) begin
                  held_in[count_ff[0]] = data;
               end else begin
                  result.payload_valid = 1'b1;
                  result.payload_byte  = held_ff[0];
                  crc_in               = crc_byte(crc_ff, held_ff[0]);
                  held_in[0]           = held_ff[1];
                  held_in[1]           = data;
               end
               count_in      = count_ff + CNT_W'(1);
               phase_in      = PH_RECV;
               result.status = ST_PENDING;
            end
         end
      end
   end

endmodule

>>> hdl/hdlc_dfr_checker.sv
`include "hdlc_async_deframer_fcs_check_defines.svh"

module hdlc_dfr_checker import hdlc_dfr_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [2:0]             rsp_status,
   input logic                   rsp_payload_valid,
   input logic [7:0]             rsp_payload_byte,
   input logic [FRAME_LEN_W-1:0] rsp_frame_length
);

   // A released data byte only ever comes with a pending status.
   `HDLC_DFR_ASSERT_NOW(a_payload_pending, rsp_valid && rsp_payload_valid, rsp_status == ST_PENDING, "payload word without pending status")

   // Without a data byte the byte field reads as zero.
   `HDLC_DFR_ASSERT_NOW(a_payload_zero, rsp_valid && !rsp_payload_valid, rsp_payload_byte == 8'd0, "payload byte not zero while invalid")

   // The frame length is only reported with a good frame.
   `HDLC_DFR_ASSERT_NOW(a_length_good, rsp_valid && (rsp_status != ST_GOOD), rsp_frame_length == '0, "frame length outside a good frame")

   // A stalled result word holds.
   `HDLC_DFR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_payload_valid) && $stable(rsp_payload_byte) && $stable(rsp_frame_length), "stalled result word changed")

   // The input only stalls behind a full, stalled result register.
   `HDLC_DFR_ASSERT_NOW(a_req_stall, req_stall, rsp_valid && rsp_stall, "input stalled without a stalled result word")

endmodule

bind hdlc_async_deframer_fcs_check hdlc_dfr_checker u_checker (.*);

>>> dv/hdlc_async_deframer_fcs_check_tb.sv
`timescale 1ns / 100ps

module hdlc_async_deframer_fcs_check_tb;
   import hdlc_dfr_pkg::*;

   typedef logic [7:0] octet_queue_type[$];

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CFG_W-1:0]       csr_write_data   = '0;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_rx_byte      = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic [2:0]             rsp_status;
   logic                   rsp_payload_valid;
   logic [7:0]             rsp_payload_byte;
   logic [FRAME_LEN_W-1:0] rsp_frame_length;

   hdlc_async_deframer_fcs_check dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_frame_length  (rsp_frame_length)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the deframer state.
   logic [CFG_W-1:0] limit_reg;
   phase_type        rx_state;
   logic [12:0]      byte_count;
   logic [15:0]      crc_acc;
   logic [7:0]       held [0:1];

   result_type  expected_words[$];
   result_type  oldest;
   logic        failed = 1'b0;
   int unsigned octets_sent = 0;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] d);
      logic [15:0] c;
      c = acc ^ {8'h00, d};
      repeat (8) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic [12:0] clamped_limit();
      if (limit_reg < MIN_FRAME_BYTES) begin
         return 13'(MIN_FRAME_BYTES);
      end
      if (limit_reg > MAX_FRAME_BYTES_DEF) begin
         return 13'(MAX_FRAME_BYTES_DEF);
      end
      return limit_reg;
   endfunction

   function automatic void reset_shadow();
      limit_reg  = CFG_RESET;
      rx_state   = PH_IDLE;
      byte_count = '0;
      crc_acc    = CRC_INIT;
      held[0]    = 8'h00;
      held[1]    = 8'h00;
   endfunction

   // The first two bytes of a frame only fill the delay line; later ones push
   // the oldest held byte out as payload and into the CRC.
   function automatic void store_data(input logic [7:0] b, inout result_type r);
      if (byte_count >= clamped_limit()) begin
         rx_state = PH_IDLE;
         r.status = ST_OVERFLOW;
      end else begin
         if (byte_count < 2) begin
            held[byte_count[0]] = b;
         end else begin
            r.payload_valid = 1'b1;
            r.payload_byte  = held[0];
            crc_acc = crc_step(crc_acc, held[0]);
            held[0] = held[1];
            held[1] = b;
         end
         byte_count++;
         rx_state = PH_RECV;
         r.status = ST_PENDING;
      end
   endfunction

   function automatic result_type predict_octet(input logic [7:0] b);
      result_type  r;
      logic [12:0] stored_less_fcs;
      r = '0;
      r.status = ST_IDLE;
      case (rx_state)
         PH_RECV: begin
            if (b == FLAG_OCTET) begin
               rx_state = PH_IDLE;
               if (byte_count < 2) begin
                  r.status = ST_SHORT;
               end else if ({held[1], held[0]} == (crc_acc ^ CRC_XOROUT)) begin
                  stored_less_fcs = byte_count - 13'd2;
                  r.status        = ST_GOOD;
                  r.frame_length  = stored_less_fcs[FRAME_LEN_W-1:0];
               end else begin
                  r.status = ST_BADFCS;
               end
            end else if (b == ESC_OCTET) begin
               rx_state = PH_ESC;
               r.status = ST_PENDING;
            end else begin
               store_data(b, r);
            end
         end
         PH_ESC: begin
            if (b == FLAG_OCTET) begin
               rx_state = PH_IDLE;
               r.status = ST_ABORT;
            end else begin
               store_data(b ^ ESC_XOR, r);
            end
         end
         default: begin
            rx_state = PH_IDLE;
            if (b == FLAG_OCTET) begin
               rx_state   = PH_RECV;
               byte_count = '0;
               crc_acc    = CRC_INIT;
               r.status   = ST_PENDING;
            end
         end
      endcase
      return r;
   endfunction

   function automatic void check_field(input string what, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
         failed = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected result word, status expected none, got %0d",
                     $time, rsp_status);
            failed = 1'b1;
         end else begin
            oldest = expected_words.pop_front();
            check_field("status", oldest.status, rsp_status);
            check_field("payload_valid", oldest.payload_valid, rsp_payload_valid);
            check_field("payload_byte", oldest.payload_byte, rsp_payload_byte);
            check_field("frame_length", oldest.frame_length, rsp_frame_length);
         end
      end
   end

   // Called at a rising edge; returns at the edge where the word is taken.
   task automatic send_word(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      expected_words.push_back(predict_octet(b));
      octets_sent++;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   // Flag and escape octets must be escaped; any other byte may be as well.
   task automatic send_stuffed(input logic [7:0] b);
      if (b == FLAG_OCTET || b == ESC_OCTET || $urandom_range(0, 15) == 0) begin
         send_word(ESC_OCTET);
         send_word(b ^ ESC_XOR);
      end else begin
         send_word(b);
      end
   endtask

   task automatic send_frame(input octet_queue_type data, input logic corrupt);
      logic [15:0] fcs;
      fcs = CRC_INIT;
      foreach (data[i]) begin
         fcs = crc_step(fcs, data[i]);
      end
      fcs = fcs ^ CRC_XOROUT;
      if (corrupt) begin
         fcs = fcs ^ (16'h0001 << $urandom_range(0, 15));
      end
      send_word(FLAG_OCTET);
      foreach (data[i]) begin
         send_stuffed(data[i]);
      end
      send_stuffed(fcs[7:0]);
      send_stuffed(fcs[15:8]);
      send_word(FLAG_OCTET);
   endtask

   function automatic octet_queue_type random_payload(input int unsigned n);
      octet_queue_type q;
      repeat (n) begin
         if ($urandom_range(0, 7) == 0) begin
            q.push_back($urandom_range(0, 1) ? FLAG_OCTET : ESC_OCTET);
         end else begin
            q.push_back(8'($urandom_range(0, 255)));
         end
      end
      return q;
   endfunction

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      limit_reg = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_idle_bytes();
      send_word(8'h00);
      send_word(8'hFF);
      send_word(ESC_OCTET);
      send_word(8'hA5);
   endtask

   task automatic test_short_frames();
      send_word(FLAG_OCTET);
      send_word(FLAG_OCTET);
      send_word(FLAG_OCTET);
      send_word(8'h5A);
      send_word(FLAG_OCTET);
      send_word(FLAG_OCTET);
      send_word(ESC_OCTET);
      send_word(8'h41);
      send_word(FLAG_OCTET);
   endtask

   task automatic test_empty_and_escaped();
      octet_queue_type q;
      send_frame(q, 1'b0);
      q = '{FLAG_OCTET, ESC_OCTET, ESC_XOR, 8'hFF, 8'h00};
      send_frame(q, 1'b0);
   endtask

   task automatic test_abort_and_bad_fcs();
      octet_queue_type q;
      send_word(FLAG_OCTET);
      send_word(8'h11);
      send_word(ESC_OCTET);
      send_word(FLAG_OCTET);
      q = '{8'h01, 8'h02};
      send_frame(q, 1'b1);
   endtask

   // A zero limit is raised to three stored bytes: one payload byte fits, two do not.
   task automatic test_limit_extremes();
      wait_for_drain();
      write_limit('0);
      send_frame(random_payload(1), 1'b0);
      send_frame(random_payload(2), 1'b0);
      wait_for_drain();
      write_limit(13'(MIN_FRAME_BYTES));
      send_frame(random_payload(0), 1'b0);
      send_frame(random_payload(1), 1'b0);
      send_frame(random_payload(2), 1'b0);
      wait_for_drain();
      write_limit(13'd5);
      send_frame(random_payload(3), 1'b0);
      send_frame(random_payload(4), 1'b0);
   endtask

   // An all-ones limit is cut back to the largest frame the block holds, so long
   // frames still pass.
   task automatic test_max_length();
      wait_for_drain();
      write_limit('1);
      send_frame(random_payload(40), 1'b0);
      send_frame(random_payload(120), 1'b0);
      wait_for_drain();
      write_limit(13'(MAX_FRAME_BYTES_DEF));
      send_frame(random_payload(6), 1'b0);
   endtask

   task automatic test_random_traffic();
      int unsigned idle_set [4] = '{0, 86, 0, 13};
      int unsigned stall_set [4] = '{0, 0, 86, 13};
      int unsigned target;
      int unsigned choice;
      int unsigned len;
      logic [12:0] eff;
      logic        mid_drained;
      for (int p = 0; p < 4; p++) begin
         wait_for_drain();
         send_idle_pct = idle_set[p];
         stall_pct     = stall_set[p];
         case ($urandom_range(0, 7))
            0: write_limit(13'($urandom_range(0, 2)));
            1: write_limit('1);
            default: write_limit(13'($urandom_range(3, 24)));
         endcase
         target      = octets_sent + 260;
         mid_drained = 1'b0;
         while (octets_sent < target) begin
            // Let the block run dry once in every phase.
            if (!mid_drained && octets_sent + 130 >= target) begin
               wait_for_drain();
               mid_drained = 1'b1;
            end
            eff    = clamped_limit();
            choice = $urandom_range(0, 99);
            len    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 8);
            if (choice < 60) begin
               send_frame(random_payload(len), 1'b0);
            end else if (choice < 70) begin
               send_frame(random_payload(len), 1'b1);
            end else if (choice < 78) begin
               send_word(FLAG_OCTET);
               repeat ($urandom_range(0, 4)) send_stuffed(8'($urandom_range(0, 255)));
               send_word(ESC_OCTET);
               send_word(FLAG_OCTET);
            end else if (choice < 86) begin
               send_word(FLAG_OCTET);
               if ($urandom_range(0, 1) == 1) begin
                  send_stuffed(8'($urandom_range(0, 255)));
               end
               send_word(FLAG_OCTET);
            end else if (choice < 94) begin
               repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(0, 255)));
            end else begin
               // For limits up to 64: frames right at the limit, one byte short of it, or one byte over.
               if (eff > 64) begin
                  len = $urandom_range(0, 30);
               end else begin
                  len = eff - 3 + $urandom_range(0, 2);
               end
               send_frame(random_payload(len), 1'b0);
            end
         end
      end
   endtask

   initial begin
      reset_shadow();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_idle_bytes();
      test_short_frames();
      test_empty_and_escaped();
      test_abort_and_bad_fcs();
      test_limit_extremes();
      test_max_length();
      test_random_traffic();
      wait_for_drain();
      repeat (8) @(posedge clock);
      if (!failed && expected_words.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("tb: failure");
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/hdlc_dfr_pkg.sv
hdl/hdlc_dfr_core.sv
hdl/hdlc_async_deframer_fcs_check.sv
hdl/hdlc_dfr_checker.sv
dv/hdlc_async_deframer_fcs_check_tb.sv
